@@ rtl/psb_pkg.sv @@
// Package for the SPI PSRAM burst sequencer: sizes, op and kind codes,
// command bytes and the job record passed from the front to the back.
// No dependencies.
package psb_pkg;

    localparam int ADDR_BITS  = 24;
    localparam int MAX_BURST  = 1024;
    localparam int BUS_ADDR_W = 24;
    localparam int LEN_W      = 25;
    localparam int CFG_W      = 11;
    localparam int BL_W       = $clog2(MAX_BURST + 1);
    localparam int STEP_W     = 3;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_RESET = 3'd3;
    localparam logic [2:0] OP_ID    = 3'd4;

    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_ADDR  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_DUMMY = 2'd3;

    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_WRITE  = 8'h02;
    localparam logic [7:0] CMD_RST_EN = 8'h66;
    localparam logic [7:0] CMD_RST    = 8'h99;
    localparam logic [7:0] CMD_ID     = 8'h9F;

    localparam logic                 CFG_BURST_SIZE = 1'b0;
    localparam logic                 CFG_DUMMY_BYTE = 1'b1;
    localparam logic [CFG_W-1:0]     BURST_RESET    = CFG_W'(32);
    localparam logic [7:0]           DUMMY_RESET    = 8'hFF;

    typedef enum logic [1:0] {
        JOB_DATA,
        JOB_BURST,
        JOB_RESET,
        JOB_ID
    } t_job_type;

    typedef struct packed {
        t_job_type              jtype;
        logic                   is_write;
        logic                   cs_end;
        logic [BUS_ADDR_W-1:0]  address;
        logic [7:0]             data_byte;
    } t_job;

    typedef struct packed {
        logic            busy;
        logic [BL_W-1:0] burst_left;
    } t_front_status;

endpackage

@@ rtl/psb_front.sv @@
// Front end: accepts input transactions, tracks the request and burst state
// and pushes one job per byte group into the queue. Uses psb_pkg.
module psb_front import psb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_op,
    input  logic [23:0]       i_address,
    input  logic [LEN_W-1:0]  i_length,
    input  logic [7:0]        i_data_byte,
    input  logic [CFG_W-1:0]  i_burst_size,
    input  logic              i_q_full,
    output logic              o_push,
    output t_job              o_job,
    output t_front_status     o_status
);

    logic [ADDR_BITS-1:0] r_next_address, n_next_address;
    logic [LEN_W-1:0]     r_remaining, n_remaining;
    logic [BL_W-1:0]      r_burst_left, n_burst_left;
    logic                 r_busy, n_busy;
    logic                 r_is_write, n_is_write;

    logic [BL_W-1:0]      w_eff;
    logic [BL_W-1:0]      w_start_bl;
    logic [BL_W-1:0]      w_bl_dec;
    logic [LEN_W-1:0]     w_rem_dec;
    logic [31:0]          w_addr32;
    logic                 w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_address <= '0;
            r_remaining    <= '0;
            r_burst_left   <= '0;
            r_busy         <= 1'b0;
            r_is_write     <= 1'b0;
        end else begin
            r_next_address <= n_next_address;
            r_remaining    <= n_remaining;
            r_burst_left   <= n_burst_left;
            r_busy         <= n_busy;
            r_is_write     <= n_is_write;
        end
    end

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_addr32 = 32'(r_next_address);

    always_comb begin
        if (i_burst_size == '0) begin
            w_eff = BL_W'(1);
        end else if (32'(i_burst_size) > MAX_BURST) begin
            w_eff = BL_W'(MAX_BURST);
        end else begin
            w_eff = BL_W'(i_burst_size);
        end
        if (LEN_W'(w_eff) < r_remaining) begin
            w_start_bl = w_eff;
        end else begin
            w_start_bl = BL_W'(r_remaining);
        end
        w_bl_dec  = (r_burst_left == '0) ? w_start_bl - 1'b1 : r_burst_left - 1'b1;
        w_rem_dec = r_remaining - 1'b1;
    end

    always_comb begin
        n_next_address  = r_next_address;
        n_remaining     = r_remaining;
        n_burst_left    = r_burst_left;
        n_busy          = r_busy;
        n_is_write      = r_is_write;
        o_push          = 1'b0;
        o_job.jtype     = JOB_DATA;
        o_job.is_write  = r_is_write;
        o_job.cs_end    = (w_rem_dec == '0) || (w_bl_dec == '0);
        o_job.address   = w_addr32[BUS_ADDR_W-1:0];
        o_job.data_byte = i_data_byte;
        if (w_accept) begin
            case (i_op)
                OP_DATA: begin
                    if (r_busy) begin
                        o_push         = 1'b1;
                        o_job.jtype    = (r_burst_left == '0) ? JOB_BURST : JOB_DATA;
                        n_burst_left   = w_bl_dec;
                        n_remaining    = w_rem_dec;
                        n_next_address = r_next_address + 1'b1;
                        if (w_rem_dec == '0) begin
                            n_busy       = 1'b0;
                            n_burst_left = '0;
                        end
                    end
                end
                OP_READ, OP_WRITE: begin
                    if (!r_busy && i_length != '0) begin
                        n_next_address = ADDR_BITS'(32'(i_address));
                        n_remaining    = i_length;
                        n_burst_left   = '0;
                        n_is_write     = (i_op == OP_WRITE);
                        n_busy         = 1'b1;
                    end
                end
                OP_RESET: begin
                    if (!r_busy) begin
                        o_push      = 1'b1;
                        o_job.jtype = JOB_RESET;
                    end
                end
                OP_ID: begin
                    if (!r_busy) begin
                        o_push      = 1'b1;
                        o_job.jtype = JOB_ID;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.busy       = r_busy;
    assign o_status.burst_left = r_burst_left;

endmodule

@@ rtl/psb_queue.sv @@
// Two-entry job queue between the front and the back end.
// Uses psb_pkg for the job record and depth.
module psb_queue import psb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_job  o_head,
    output logic [Q_CNT_W-1:0] o_count
);

    t_job                 r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == Q_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == Q_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (32'(r_count) == Q_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ rtl/psb_back.sv @@
// Back end: expands the job at the queue head into bus bytes, one per cycle while i_stall
// is low, through a registered output stage. Uses psb_pkg.
module psb_back import psb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    input  logic [7:0]  i_dummy_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_cs_start,
    output logic        o_cs_end,
    output logic [1:0]  o_kind,
    output logic        o_last
);

    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    logic [7:0]        r_tx_byte;
    logic              r_cs_start;
    logic              r_cs_end;
    logic [1:0]        r_kind;
    logic              r_last;

    logic              w_load;
    logic [7:0]        w_byte;
    logic              w_cs_start;
    logic              w_cs_end;
    logic [1:0]        w_kind;
    logic              w_final;
    logic [7:0]        w_data;
    logic [1:0]        w_data_kind;

    assign w_load      = !i_empty && (!r_valid || !i_stall);
    assign o_pop       = w_load && w_final;
    assign w_data      = i_head.is_write ? i_head.data_byte : i_dummy_byte;
    assign w_data_kind = i_head.is_write ? KIND_WRITE : KIND_DUMMY;

    always_comb begin
        w_byte     = w_data;
        w_cs_start = 1'b0;
        w_cs_end   = 1'b0;
        w_kind     = KIND_CMD;
        w_final    = 1'b0;
        case (i_head.jtype)
            JOB_DATA: begin
                w_kind   = w_data_kind;
                w_cs_end = i_head.cs_end;
                w_final  = 1'b1;
            end
            JOB_BURST: begin
                case (r_step)
                    3'd0: begin
                        w_byte     = i_head.is_write ? CMD_WRITE : CMD_READ;
                        w_cs_start = 1'b1;
                    end
                    3'd1: begin
                        w_byte = i_head.address[23:16];
                        w_kind = KIND_ADDR;
                    end
                    3'd2: begin
                        w_byte = i_head.address[15:8];
                        w_kind = KIND_ADDR;
                    end
                    3'd3: begin
                        w_byte = i_head.address[7:0];
                        w_kind = KIND_ADDR;
                    end
                    default: begin
                        w_kind   = w_data_kind;
                        w_cs_end = i_head.cs_end;
                        w_final  = 1'b1;
                    end
                endcase
            end
            JOB_RESET: begin
                if (r_step == '0) begin
                    w_byte     = CMD_RST_EN;
                    w_cs_start = 1'b1;
                end else begin
                    w_byte   = CMD_RST;
                    w_cs_end = 1'b1;
                    w_final  = 1'b1;
                end
            end
            JOB_ID: begin
                case (r_step)
                    3'd0: begin
                        w_byte     = CMD_ID;
                        w_cs_start = 1'b1;
                    end
                    3'd1, 3'd2, 3'd3: begin
                        w_byte = 8'h00;
                        w_kind = KIND_ADDR;
                    end
                    3'd4, 3'd5: begin
                        w_byte = i_dummy_byte;
                        w_kind = KIND_DUMMY;
                    end
                    default: begin
                        w_byte   = i_dummy_byte;
                        w_kind   = KIND_DUMMY;
                        w_cs_end = 1'b1;
                        w_final  = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_step  <= w_final ? '0 : r_step + 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tx_byte  <= w_byte;
            r_cs_start <= w_cs_start;
            r_cs_end   <= w_cs_end;
            r_kind     <= w_kind;
            r_last     <= w_final;
        end
    end

    assign o_valid    = r_valid;
    assign o_tx_byte  = r_tx_byte;
    assign o_cs_start = r_cs_start;
    assign o_cs_end   = r_cs_end;
    assign o_kind     = r_kind;
    assign o_last     = r_last;

endmodule

@@ rtl/spi_psram_burst_sequencer.sv @@
// Top level of the SPI PSRAM burst sequencer: configuration registers,
// front end, job queue and byte back end. Uses psb_pkg and all psb_ modules.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_op, i_address, i_length, i_data_byte
//   output   out        o_valid / i_stall   o_tx_byte, o_cs_start, o_cs_end, o_kind, o_last
//   config   in         i_cfg_we            i_cfg_index, i_cfg_data
//
// The output stage sends one byte per cycle while i_stall is low; a transaction yields
// bytes as follows: none for requests, which are only taken in at the input, one for a
// data slot inside a burst, five at a burst start, two for reset, seven for read-id, all
// through the single output byte register. The front takes a new transaction every
// cycle while the two-entry job queue has room. Reset is synchronous and clears control
// state only. o_stall rises only when the queue is full; i_stall holds the output register.
module spi_psram_burst_sequencer import psb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_op,
    input  logic [23:0]       i_address,
    input  logic [LEN_W-1:0]  i_length,
    input  logic [7:0]        i_data_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_tx_byte,
    output logic              o_cs_start,
    output logic              o_cs_end,
    output logic [1:0]        o_kind,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [CFG_W-1:0]    r_burst_size;
    logic [7:0]          r_dummy_byte;

    logic                w_push;
    logic                w_pop;
    logic                w_full;
    logic                w_empty;
    t_job                w_job;
    t_job                w_head;
    t_front_status       w_status;
    logic [Q_CNT_W-1:0]  w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_size <= BURST_RESET;
            r_dummy_byte <= DUMMY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BURST_SIZE: r_burst_size <= i_cfg_data;
                CFG_DUMMY_BYTE: r_dummy_byte <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    psb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_length     (i_length),
        .i_data_byte  (i_data_byte),
        .i_burst_size (r_burst_size),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_job        (w_job),
        .o_status     (w_status)
    );

    psb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head),
        .o_count (w_count)
    );

    psb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_dummy_byte (r_dummy_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tx_byte    (o_tx_byte),
        .o_cs_start   (o_cs_start),
        .o_cs_end     (o_cs_end),
        .o_kind       (o_kind),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    a_idle_no_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_status.busy |-> (w_status.burst_left == '0))
        else $error("burst count left over while idle");

    a_cs_start_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cs_start) |-> (o_kind == KIND_CMD))
        else $error("frame opened by a non-command byte");

    a_cs_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_cs_end) |-> o_last)
        else $error("frame closed before the final byte of a transaction");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(w_count) <= Q_DEPTH) && !(w_pop && w_empty))
        else $error("job queue overflow or underflow");
`endif

endmodule

@@ dv/psb_stream_checker.sv @@
// Scoreboard for the SPI PSRAM burst sequencer: follows register writes, predicts the
// byte stream for every accepted input transaction and compares each output transaction.
// Depends on psb_pkg.
module psb_stream_checker import psb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [2:0]        i_op,
    input  logic [23:0]       i_address,
    input  logic [LEN_W-1:0]  i_length,
    input  logic [7:0]        i_data_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [7:0]        i_tx_byte,
    input  logic              i_cs_start,
    input  logic              i_cs_end,
    input  logic [1:0]        i_kind,
    input  logic              i_last,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       cs_start;
        logic       cs_end;
        logic [1:0] kind;
        logic       last;
    } t_bus_byte;

    t_bus_byte              bus_bytes_due[$];
    t_bus_byte              want_byte;
    t_bus_byte              seen_byte;
    logic [CFG_W-1:0]       burst_cfg = BURST_RESET;
    logic [7:0]             dummy_cfg = DUMMY_RESET;
    logic [ADDR_BITS-1:0]   cur_addr  = '0;
    logic [LEN_W-1:0]       bytes_owed = '0;
    logic [CFG_W-1:0]       burst_owed = '0;
    logic                   req_open  = 1'b0;
    logic                   req_write = 1'b0;
    int                     mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic queue_byte(input logic [7:0] b, input logic s, input logic e,
                              input logic [1:0] k, input logic l);
        bus_bytes_due.push_back('{b, s, e, k, l});
    endtask

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $write("[%0t] %s: expected byte=%02h cs_start=%0b cs_end=%0b kind=%0d last=%0b",
                   $time, what, want_byte.tx_byte, want_byte.cs_start, want_byte.cs_end,
                   want_byte.kind, want_byte.last);
            $display(", got byte=%02h cs_start=%0b cs_end=%0b kind=%0d last=%0b",
                     seen_byte.tx_byte, seen_byte.cs_start, seen_byte.cs_end, seen_byte.kind,
                     seen_byte.last);
        end
    endtask

    task automatic predict_spi_bytes(input logic [2:0] op, input logic [23:0] addr,
                                     input logic [LEN_W-1:0] len, input logic [7:0] data);
        int span;
        logic [23:0] bus_addr;
        if (op == OP_DATA) begin
            if (req_open) begin
                if (burst_owed == 0) begin
                    span = (burst_cfg == 0) ? 1 : (burst_cfg > MAX_BURST) ? MAX_BURST
                                                                          : int'(burst_cfg);
                    burst_owed = (span < bytes_owed) ? CFG_W'(span) : CFG_W'(bytes_owed);
                    bus_addr = cur_addr[23:0];
                    queue_byte(req_write ? CMD_WRITE : CMD_READ, 1'b1, 1'b0, KIND_CMD, 1'b0);
                    queue_byte(bus_addr[23:16], 1'b0, 1'b0, KIND_ADDR, 1'b0);
                    queue_byte(bus_addr[15:8], 1'b0, 1'b0, KIND_ADDR, 1'b0);
                    queue_byte(bus_addr[7:0], 1'b0, 1'b0, KIND_ADDR, 1'b0);
                end
                burst_owed = burst_owed - 1'b1;
                bytes_owed = bytes_owed - 1'b1;
                cur_addr   = cur_addr + 1'b1;
                if (bytes_owed == 0) begin
                    req_open   = 1'b0;
                    burst_owed = '0;
                end
                queue_byte(req_write ? data : dummy_cfg, 1'b0, burst_owed == 0,
                           req_write ? KIND_WRITE : KIND_DUMMY, 1'b1);
            end
        end else if (req_open || op > OP_ID) begin
            // drop: busy or unknown op
        end else if (op == OP_READ || op == OP_WRITE) begin
            if (len != 0) begin
                cur_addr   = ADDR_BITS'(addr);
                bytes_owed = len;
                burst_owed = '0;
                req_write  = (op == OP_WRITE);
                req_open   = 1'b1;
            end
        end else if (op == OP_RESET) begin
            queue_byte(CMD_RST_EN, 1'b1, 1'b0, KIND_CMD, 1'b0);
            queue_byte(CMD_RST, 1'b0, 1'b1, KIND_CMD, 1'b1);
        end else begin
            queue_byte(CMD_ID, 1'b1, 1'b0, KIND_CMD, 1'b0);
            repeat (3) queue_byte(8'h00, 1'b0, 1'b0, KIND_ADDR, 1'b0);
            queue_byte(dummy_cfg, 1'b0, 1'b0, KIND_DUMMY, 1'b0);
            queue_byte(dummy_cfg, 1'b0, 1'b0, KIND_DUMMY, 1'b0);
            queue_byte(dummy_cfg, 1'b0, 1'b1, KIND_DUMMY, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            burst_cfg  = BURST_RESET;
            dummy_cfg  = DUMMY_RESET;
            cur_addr   = '0;
            bytes_owed = '0;
            burst_owed = '0;
            req_open   = 1'b0;
            req_write  = 1'b0;
            bus_bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BURST_SIZE) begin
                    burst_cfg = i_cfg_data;
                end else begin
                    dummy_cfg = i_cfg_data[7:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_spi_bytes(i_op, i_address, i_length, i_data_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                seen_byte = '{i_tx_byte, i_cs_start, i_cs_end, i_kind, i_last};
                if (bus_bytes_due.size() == 0) begin
                    want_byte = 'x;
                    note_failure("unexpected output transaction");
                end else begin
                    want_byte = bus_bytes_due.pop_front();
                    if (want_byte.tx_byte !== seen_byte.tx_byte
                        || want_byte.cs_start !== seen_byte.cs_start
                        || want_byte.cs_end !== seen_byte.cs_end
                        || want_byte.kind !== seen_byte.kind
                        || want_byte.last !== seen_byte.last) begin
                        note_failure("output mismatch");
                    end
                end
            end
        end
        o_pending <= bus_bytes_due.size();
    end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the SPI PSRAM burst sequencer: clock, reset, stimulus with random
// idling on both channels and the verdict. Depends on psb_pkg, the block and
// psb_stream_checker.
module tb_top;
    import psb_pkg::*;

    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         ITEM_TARGET   = 480;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         LONG_HOLD     = 300;
    localparam int         LONG_REQUEST  = 40;
    localparam logic [2:0] OP_RSVD_LO    = 3'd5;
    localparam logic [2:0] OP_RSVD_HI    = 3'd7;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic [2:0]        i_op        = OP_READ;
    logic [23:0]       i_address   = '0;
    logic [LEN_W-1:0]  i_length    = '0;
    logic [7:0]        i_data_byte = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic [7:0]        o_tx_byte;
    logic              o_cs_start;
    logic              o_cs_end;
    logic [1:0]        o_kind;
    logic              o_last;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_index = CFG_BURST_SIZE;
    logic [CFG_W-1:0]  i_cfg_data  = '0;

    int fail_count;
    int pending;
    int cycles       = 0;
    int open_slots   = 0;
    int items_sent   = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    spi_psram_burst_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_address   (i_address),
        .i_length    (i_length),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tx_byte   (o_tx_byte),
        .o_cs_start  (o_cs_start),
        .o_cs_end    (o_cs_end),
        .o_kind      (o_kind),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    psb_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_length     (i_length),
        .i_data_byte  (i_data_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_tx_byte    (o_tx_byte),
        .i_cs_start   (o_cs_start),
        .i_cs_end     (o_cs_end),
        .i_kind       (o_kind),
        .i_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic issue(input logic [2:0] op, input logic [23:0] addr,
                         input logic [LEN_W-1:0] len, input logic [7:0] data);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_address   <= addr;
        i_length    <= len;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (op == OP_DATA) begin
            if (open_slots > 0) open_slots--;
        end else if ((op == OP_READ || op == OP_WRITE) && open_slots == 0) begin
            open_slots = len;
        end
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] burst, input logic [CFG_W-1:0] dummy);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_BURST_SIZE;
        i_cfg_data  <= burst;
        @(posedge i_clk);
        i_cfg_index <= CFG_DUMMY_BYTE;
        i_cfg_data  <= dummy;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] burst_pick;
        logic [LEN_W-1:0] req_len;
        logic [23:0]      req_addr;
        int               phase_len;
        int               r;
        int               phase_no;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values, fixed sequences and ignored items
        issue(OP_RESET, '0, '0, '0);
        issue(OP_ID, '1, '1, '1);
        issue(OP_DATA, 24'($urandom), LEN_W'($urandom), 8'($urandom));
        issue(OP_RSVD_HI, '1, '1, '1);
        issue(OP_READ, 24'h000010, '0, '0);
        // write across the top of the address space
        issue(OP_WRITE, 24'hFFFFFE, LEN_W'(3), '0);
        issue(OP_DATA, '0, '0, 8'h00);
        issue(OP_DATA, '1, '1, 8'hFF);
        issue(OP_DATA, 24'($urandom), LEN_W'($urandom), 8'hA5);
        // requests while busy
        issue(OP_READ, '0, LEN_W'(2), '0);
        issue(OP_ID, '0, '0, '0);
        issue(OP_RESET, '0, '0, '0);
        issue(OP_WRITE, 24'hFFFFFF, LEN_W'(25'h1000000), 8'hFF);
        issue(OP_RSVD_LO, '0, '0, '0);
        issue(OP_DATA, 24'($urandom), LEN_W'($urandom), 8'($urandom));
        issue(OP_DATA, 24'($urandom), LEN_W'($urandom), 8'($urandom));
        drain;

        // burst size zero acts as one
        program_regs('0, '0);
        issue(OP_READ, 24'h123456, LEN_W'(3), '0);
        repeat (3) issue(OP_DATA, 24'($urandom), LEN_W'($urandom), 8'($urandom));
        issue(OP_ID, '0, '0, '0);
        drain;

        // oversize burst saturates
        program_regs('1, 11'h7AA);
        issue(OP_READ, 24'hFFFF00, LEN_W'(LONG_REQUEST), '0);
        repeat (LONG_REQUEST) issue(OP_DATA, 24'($urandom), LEN_W'($urandom), 8'($urandom));
        drain;

        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0:       burst_pick = '0;
                1:       burst_pick = CFG_W'(1);
                2:       burst_pick = CFG_W'(2);
                3:       burst_pick = CFG_W'(MAX_BURST);
                4:       burst_pick = CFG_W'($urandom);
                default: burst_pick = CFG_W'($urandom_range(3, 40));
            endcase
            program_regs(burst_pick, CFG_W'($urandom));
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 40;
            endcase
            if (phase_no == 2) hold_request = 1'b1;
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                if (open_slots > 0) begin
                    if (r < 88) begin
                        issue(OP_DATA, 24'($urandom), LEN_W'($urandom), 8'($urandom));
                    end else begin
                        issue(3'($urandom), 24'($urandom), LEN_W'($urandom), 8'($urandom));
                    end
                end else if (r < 60) begin
                    req_len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(0, 70))
                                                          : LEN_W'($urandom_range(1, 12));
                    req_addr = ($urandom_range(0, 3) == 0)
                             ? 24'(24'hFFFFFF - $urandom_range(0, 8)) : 24'($urandom);
                    issue($urandom_range(0, 1) ? OP_WRITE : OP_READ, req_addr, req_len,
                          8'($urandom));
                end else if (r < 75) begin
                    issue((r < 68) ? OP_RESET : OP_ID, 24'($urandom), LEN_W'($urandom),
                          8'($urandom));
                end else if (r < 85) begin
                    issue(OP_DATA, 24'($urandom), LEN_W'($urandom), 8'($urandom));
                end else begin
                    issue(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), 24'($urandom),
                          LEN_W'($urandom), 8'($urandom));
                end
                if (items_sent >= ITEM_TARGET * 85 / 100) calm = 1'b1;
            end
            drain;
            phase_no++;
        end

        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
